>>> design/lfpid_pkg.sv
// ---------------------------------------------------------------------------
// lfpid_pkg
// shared widths, register indexes, drive mode codes and fixed spin duties
// ---------------------------------------------------------------------------
package lfpid_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int SPEED_W = 13;
  localparam int GAIN_W  = 16;
  localparam int WGT_W   = 4;
  localparam int ERR_W   = 5;
  localparam int ACC_W   = 32;
  localparam int DUTY_W  = 13;
  localparam int FUNC_W  = 2;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PRESET_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_WEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_WEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_GAIN    = 3'd6;

  localparam logic [FUNC_W-1:0] FUNC_FOLLOW = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SPIN   = 2'd2;

  localparam logic [SPEED_W-1:0] PRESET_SPEED_RST = 13'd3000;
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 16'd1500;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 16'd1;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 16'd4000;
  localparam logic [WGT_W-1:0]   OUTER_WEIGHT_RST = 4'd3;
  localparam logic [WGT_W-1:0]   INNER_WEIGHT_RST = 4'd1;
  localparam logic [WGT_W-1:0]   SLOW_GAIN_RST    = 4'd1;

  localparam int SPIN_LEFT_DUTY  = 2500;
  localparam int SPIN_RIGHT_DUTY = 3500;

endpackage

>>> design/line_follow_pid_motor_mixer_core.sv
// ---------------------------------------------------------------------------
// line_follow_pid_motor_mixer_core
// incremental pid on a line-sensor error, mixed into two pwm drive sides
// ---------------------------------------------------------------------------
// One request is taken when the block is idle; it steps through the sequencer
// states, and in the mix state its result is loaded into the output register
// once the output is free, after which the block returns to idle. The work is
// done on a single shared 17 x 33 bit signed multiplier, registered at its
// output, which forms the three gain products of the pid update and then the
// slow-down product for the base speed under a small sequencer. A finished
// result waits in the output register, so the next request is accepted while
// it is still pending downstream.
// ---------------------------------------------------------------------------
module line_follow_pid_motor_mixer_core
  import lfpid_pkg::*;
#(
  parameter int PWM_LIMIT = 7199
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // left_outer, left_inner, right_inner, right_outer, func[1:0], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // left_enable, left_forward, left_duty[12:0], right_enable, right_forward,
  // right_duty[12:0], drive_value[31:0], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SUM_W = 35;
  localparam int MA_W  = 17;
  localparam int MB_W  = 33;
  localparam int PR_W  = MA_W + MB_W;
  localparam int MIX_W = 34;
  localparam int SIDE_W = DUTY_W + 2;

  localparam logic [31:0] SPIN_L_LIM =
    (PWM_LIMIT < SPIN_LEFT_DUTY) ? 32'(PWM_LIMIT) : 32'(SPIN_LEFT_DUTY);
  localparam logic [31:0] SPIN_R_LIM =
    (PWM_LIMIT < SPIN_RIGHT_DUTY) ? 32'(PWM_LIMIT) : 32'(SPIN_RIGHT_DUTY);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL_P = 4'd1;
  localparam logic [3:0] S_MUL_I = 4'd2;
  localparam logic [3:0] S_MUL_D = 4'd3;
  localparam logic [3:0] S_ADD_D = 4'd4;
  localparam logic [3:0] S_SAT   = 4'd5;
  localparam logic [3:0] S_MUL_S = 4'd6;
  localparam logic [3:0] S_BASE  = 4'd7;
  localparam logic [3:0] S_MIX   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  logic [SPEED_W-1:0] preset_speed;
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  integ_gain;
  logic [GAIN_W-1:0]  deriv_gain;
  logic [WGT_W-1:0]   outer_weight;
  logic [WGT_W-1:0]   inner_weight;
  logic [WGT_W-1:0]   slow_gain;

  logic signed [ERR_W-1:0] error_now;
  logic signed [ERR_W-1:0] error_prev;
  logic signed [ERR_W-1:0] error_prev2;
  logic signed [ACC_W-1:0] drive_acc;

  logic [FUNC_W-1:0]       func_q;
  logic signed [SUM_W-1:0] sum;
  logic signed [PR_W-1:0]  prod;
  logic [ACC_W-1:0]        mag;
  logic [SPEED_W-1:0]      base;

  logic                    in_fire;
  logic                    out_free;
  logic                    out_load;
  logic                    lo, li, ri, ro;
  logic [FUNC_W-1:0]       in_func;
  logic signed [ERR_W-1:0] err_new;
  logic signed [ERR_W-1:0] w_outer;
  logic signed [ERR_W-1:0] w_inner;
  logic signed [7:0]       d1;
  logic signed [7:0]       d2;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [SUM_W-1:0] prod_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic signed [ACC_W:0]   acc_ext;
  logic signed [ACC_W:0]   acc_neg;
  logic signed [MIX_W-1:0] base_s;
  logic signed [MIX_W-1:0] acc_s;
  logic [SIDE_W-1:0]       left_side;
  logic [SIDE_W-1:0]       right_side;
  logic                    left_enable, left_forward, right_enable, right_forward;
  logic [DUTY_W-1:0]       left_duty, right_duty;

  // returns {enable, forward, duty} for one side after the pwm clamp
  function automatic logic [SIDE_W-1:0] mix_side(input logic signed [MIX_W-1:0] v);
    logic signed [MIX_W-1:0] lim;
    logic signed [MIX_W-1:0] c;
    logic signed [MIX_W-1:0] n;
    lim = $signed(MIX_W'(PWM_LIMIT));
    if (v > lim) begin
      c = lim;
    end else if (v < -lim) begin
      c = -lim;
    end else begin
      c = v;
    end
    n = -c;
    if (c > 0) begin
      mix_side = {1'b1, 1'b1, c[DUTY_W-1:0]};
    end else begin
      mix_side = {1'b1, 1'b0, n[DUTY_W-1:0]};
    end
  endfunction

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = (state == S_MIX) && out_free;

  assign lo      = s_axis_tdata[0];
  assign li      = s_axis_tdata[1];
  assign ri      = s_axis_tdata[2];
  assign ro      = s_axis_tdata[3];
  assign in_func = s_axis_tdata[5:4];

  // both inner sensors on the line: steer on the outer pair; otherwise on the inner pair
  always_comb begin
    w_outer = $signed({1'b0, outer_weight});
    w_inner = $signed({1'b0, inner_weight});
    if (li && ri) begin
      if (lo && !ro) begin
        err_new = w_outer;
      end else if (!lo && ro) begin
        err_new = -w_outer;
      end else begin
        err_new = '0;
      end
    end else begin
      if (li && !ri) begin
        err_new = w_inner;
      end else if (!li && ri) begin
        err_new = -w_inner;
      end else begin
        err_new = '0;
      end
    end
  end

  assign d1 = 8'(error_now) - 8'(error_prev);
  assign d2 = 8'(error_now) - (8'(error_prev) <<< 1) + 8'(error_prev2);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_P: begin
        mul_a = $signed({1'b0, prop_gain});
        mul_b = MB_W'(d1);
      end
      S_MUL_I: begin
        mul_a = $signed({1'b0, integ_gain});
        mul_b = MB_W'(error_now);
      end
      S_MUL_D: begin
        mul_a = $signed({1'b0, deriv_gain});
        mul_b = MB_W'(d2);
      end
      S_MUL_S: begin
        mul_a = $signed(MA_W'(slow_gain));
        mul_b = $signed({1'b0, mag});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_sum = prod[SUM_W-1:0];

  always_comb begin
    if (sum > $signed(SUM_W'(32'h7FFF_FFFF))) begin
      acc_sat = 32'sh7FFF_FFFF;
    end else if (sum < $signed({{(SUM_W-31){1'b1}}, 31'b0})) begin
      acc_sat = $signed({1'b1, 31'b0});
    end else begin
      acc_sat = sum[ACC_W-1:0];
    end
  end

  assign acc_ext = (ACC_W+1)'(acc_sat);
  assign acc_neg = -acc_ext;

  assign base_s     = $signed(MIX_W'(base));
  assign acc_s      = MIX_W'(drive_acc);
  assign left_side  = mix_side(base_s + acc_s);
  assign right_side = mix_side(base_s - acc_s);

  always_comb begin
    case (func_q)
      FUNC_FOLLOW: begin
        {left_enable, left_forward, left_duty}    = left_side;
        {right_enable, right_forward, right_duty} = right_side;
      end
      FUNC_SPIN: begin
        left_enable   = 1'b1;
        left_forward  = 1'b0;
        left_duty     = SPIN_L_LIM[DUTY_W-1:0];
        right_enable  = 1'b1;
        right_forward = 1'b1;
        right_duty    = SPIN_R_LIM[DUTY_W-1:0];
      end
      default: begin
        left_enable   = 1'b0;
        left_forward  = 1'b0;
        left_duty     = '0;
        right_enable  = 1'b0;
        right_forward = 1'b0;
        right_duty    = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_MUL_P;
      S_MUL_P: state_next = S_MUL_I;
      S_MUL_I: state_next = S_MUL_D;
      S_MUL_D: state_next = S_ADD_D;
      S_ADD_D: state_next = S_SAT;
      S_SAT:   state_next = S_MUL_S;
      S_MUL_S: state_next = S_BASE;
      S_BASE:  state_next = S_MIX;
      S_MIX:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      preset_speed  <= PRESET_SPEED_RST;
      prop_gain     <= PROP_GAIN_RST;
      integ_gain    <= INTEG_GAIN_RST;
      deriv_gain    <= DERIV_GAIN_RST;
      outer_weight  <= OUTER_WEIGHT_RST;
      inner_weight  <= INNER_WEIGHT_RST;
      slow_gain     <= SLOW_GAIN_RST;
      error_now     <= '0;
      error_prev    <= '0;
      error_prev2   <= '0;
      drive_acc     <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PRESET_SPEED: preset_speed <= cfg_data[SPEED_W-1:0];
          REG_PROP_GAIN:    prop_gain    <= cfg_data[GAIN_W-1:0];
          REG_INTEG_GAIN:   integ_gain   <= cfg_data[GAIN_W-1:0];
          REG_DERIV_GAIN:   deriv_gain   <= cfg_data[GAIN_W-1:0];
          REG_OUTER_WEIGHT: outer_weight <= cfg_data[WGT_W-1:0];
          REG_INNER_WEIGHT: inner_weight <= cfg_data[WGT_W-1:0];
          REG_SLOW_GAIN:    slow_gain    <= cfg_data[WGT_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        error_prev2 <= error_prev;
        error_prev  <= error_now;
        error_now   <= err_new;
      end
      if (state == S_SAT) begin
        drive_acc <= acc_sat;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_fire) begin
      func_q <= in_func;
      sum    <= SUM_W'(drive_acc);
    end
    if (state == S_MUL_I || state == S_MUL_D || state == S_ADD_D) begin
      sum <= sum + prod_sum;
    end
    if (state == S_SAT) begin
      mag <= acc_ext[ACC_W] ? acc_neg[ACC_W-1:0] : acc_ext[ACC_W-1:0];
    end
    if (state == S_BASE) begin
      if (prod > $signed(PR_W'(preset_speed))) begin
        base <= '0;
      end else begin
        base <= preset_speed - prod[SPEED_W-1:0];
      end
    end
    if (out_load) begin
      m_axis_tdata <= {2'b00, drive_acc,
                       right_duty, right_forward, right_enable,
                       left_duty, left_forward, left_enable};
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_MUL_P))
    else $error("accepted request did not start the pid sequence");

  a_drive_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_axis_tdata[61:30] == $past(drive_acc)))
    else $error("drive value in result differs from accumulator");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && func_q == FUNC_STOP) |=> (m_axis_tdata[29:0] == '0))
    else $error("stop mode result drives a bridge");

endmodule
